// File: rtl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, zone codes, register indexes and the configuration and
// hit structs of the geofence crossing counter.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int COUNT_BITS = 32;
    localparam int TOTAL_W    = 32;
    localparam int TIME_W     = 47;
    localparam int LON_W      = 26;
    localparam int LAT_W      = 25;
    localparam int BND_W      = 25;
    localparam int BOUNDS_W   = 2 * BND_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BOUNDS_W;
    localparam int IN_FLD_W   = TIME_W + LON_W + LAT_W;
    localparam int IN_DATA_W  = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = TOTAL_W + 2 + 2;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] WINDOW_END_RST = 47'd99999999999999;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX1_LON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX1_LAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX2_LON     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX2_LAT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MODE    = 3'd6;

    typedef enum logic [1:0] {
        ZONE_NONE = 2'd0,
        ZONE_ONE  = 2'd1,
        ZONE_TWO  = 2'd2
    } t_zone;

    typedef struct packed {
        logic [TIME_W-1:0]   window_start;
        logic [TIME_W-1:0]   window_end;
        logic [BOUNDS_W-1:0] box_one_lon;
        logic [BOUNDS_W-1:0] box_one_lat;
        logic [BOUNDS_W-1:0] box_two_lon;
        logic [BOUNDS_W-1:0] box_two_lat;
        logic                zone_mode;
    } t_cfg;

    typedef struct packed {
        logic in_window;
        logic hit_one;
        logic hit_two;
    } t_hits;

endpackage

// File: rtl/gcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gcc_cfg_regs
// Configuration register file: window limits, box bounds and zone mode.
// ----------------------------------------------------------------------------
module gcc_cfg_regs
    import gcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start <= '0;
            r_cfg.window_end   <= WINDOW_END_RST;
            r_cfg.box_one_lon  <= '0;
            r_cfg.box_one_lat  <= '0;
            r_cfg.box_two_lon  <= '0;
            r_cfg.box_two_lat  <= '0;
            r_cfg.zone_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_START: r_cfg.window_start <= i_cfg_data[TIME_W-1:0];
                CFG_WINDOW_END:   r_cfg.window_end   <= i_cfg_data[TIME_W-1:0];
                CFG_BOX1_LON:     r_cfg.box_one_lon  <= i_cfg_data;
                CFG_BOX1_LAT:     r_cfg.box_one_lat  <= i_cfg_data;
                CFG_BOX2_LON:     r_cfg.box_two_lon  <= i_cfg_data;
                CFG_BOX2_LAT:     r_cfg.box_two_lat  <= i_cfg_data;
                CFG_ZONE_MODE:    r_cfg.zone_mode    <= i_cfg_data[0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/gcc_zone_test.sv
// ----------------------------------------------------------------------------
// gcc_zone_test
// Time window check and inclusive box tests for one registered fix.
// ----------------------------------------------------------------------------
module gcc_zone_test
    import gcc_pkg::*;
(
    input  t_cfg                     i_cfg,
    input  logic [TIME_W-1:0]        i_fix_time,
    input  logic signed [LON_W-1:0]  i_fix_lon,
    input  logic signed [LAT_W-1:0]  i_fix_lat,
    output t_hits                    o_hits
);

    // Bounds are two signed 25-bit halves; widen both to the longitude width.
    function automatic logic span_hit(input logic signed [LON_W-1:0] v,
                                      input logic [BOUNDS_W-1:0] b);
        logic signed [LON_W-1:0] lo;
        logic signed [LON_W-1:0] hi;
        lo = LON_W'(signed'(b[BND_W-1:0]));
        hi = LON_W'(signed'(b[BOUNDS_W-1:BND_W]));
        return (v >= lo) && (v <= hi);
    endfunction

    logic signed [LON_W-1:0] lat_ext;
    logic                    in_one;
    logic                    in_two;

    assign lat_ext = LON_W'(i_fix_lat);
    assign in_one  = span_hit(i_fix_lon, i_cfg.box_one_lon) &&
                     span_hit(lat_ext, i_cfg.box_one_lat);
    assign in_two  = span_hit(i_fix_lon, i_cfg.box_two_lon) &&
                     span_hit(lat_ext, i_cfg.box_two_lat);

    assign o_hits.in_window = (i_fix_time >= i_cfg.window_start) &&
                              (i_fix_time <= i_cfg.window_end);
    assign o_hits.hit_one   = in_one;
    assign o_hits.hit_two   = i_cfg.zone_mode ? !in_one : in_two;

endmodule

// File: rtl/gcc_tally.sv
// ----------------------------------------------------------------------------
// gcc_tally
// Last-zone tracking, saturating crossing count and the result register.
// ----------------------------------------------------------------------------
module gcc_tally
    import gcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fix_valid,
    input  logic               i_track_start,
    input  t_hits              i_hits,
    input  logic               i_out_ready,
    output logic               o_advance,
    output logic               o_out_valid,
    output logic [TOTAL_W-1:0] o_total,
    output logic [1:0]         o_now,
    output t_zone              o_zone
);

    t_zone                  r_last;
    logic [COUNT_BITS-1:0]  r_count;
    logic                   r_out_valid;
    logic [1:0]             r_now;
    t_zone                  r_zone;

    t_zone                  n_last;
    logic [1:0]             n_now;
    logic [COUNT_BITS-1:0]  n_count;
    t_zone                  start_zone;
    logic [COUNT_BITS:0]    sum;

    assign o_advance = i_fix_valid && (!r_out_valid || i_out_ready);

    // Zone one is scored before zone two, so a fix in both boxes can add two.
    always_comb begin
        start_zone = i_track_start ? ZONE_NONE : r_last;
        n_last     = start_zone;
        n_now      = 2'd0;
        if (i_hits.in_window) begin
            if (i_hits.hit_one) begin
                if (n_last == ZONE_TWO) begin
                    n_now = n_now + 2'd1;
                end
                n_last = ZONE_ONE;
            end
            if (i_hits.hit_two) begin
                if (n_last == ZONE_ONE) begin
                    n_now = n_now + 2'd1;
                end
                n_last = ZONE_TWO;
            end
        end
    end

    // Carry out of the widened sum means the count passed its maximum.
    assign sum     = {1'b0, r_count} + (COUNT_BITS + 1)'(n_now);
    assign n_count = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= ZONE_NONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_last      <= n_last;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_now  <= n_now;
            r_zone <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_total     = TOTAL_W'(r_count);
    assign o_now       = r_now;
    assign o_zone      = r_zone;

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count >= $past(r_count)))
        else $error("crossing count decreased");

    a_double_ends_in_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_now == 2'd2)) |-> (r_zone == ZONE_TWO))
        else $error("two crossings without ending in zone two");

    a_cross_has_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_now != 2'd0)) |-> (r_zone == ZONE_ONE || r_zone == ZONE_TWO))
        else $error("crossing reported with no zone held");

    a_zone_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance |=> (r_zone == r_last))
        else $error("result zone differs from stored last zone");

endmodule

// File: rtl/geofence_crossing_counter.sv
// Each fix passes through the input register, then the result register, before
// its result is valid on the output.
// Throughput: one fix per cycle while the output takes results; the result register
// is refilled in the cycle its result is taken, so input ready follows output ready.
// Reset (synchronous, active low) clears the last zone, the crossing count and
// both valid flags, and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// geofence_crossing_counter
// Counts transitions between zone one and zone two over a stream of fixes.
// ----------------------------------------------------------------------------
module geofence_crossing_counter
    import gcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // fix_time[46:0], fix_lon[72:47], fix_lat[97:73], zero pad[103:98]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // track_start[0]
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // crossing_total[31:0], crossings_now[33:32], zone_now[35:34], zero pad[39:36]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                    cfg;
    t_hits                   hits;
    logic                    advance;
    logic [TOTAL_W-1:0]      total;
    logic [1:0]              now_cnt;
    t_zone                   zone;

    logic                    r_in_valid;
    logic [TIME_W-1:0]       r_time;
    logic signed [LON_W-1:0] r_lon;
    logic signed [LAT_W-1:0] r_lat;
    logic                    r_track;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // hold the fix while the result side stalls
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_time  <= i_s_tdata[TIME_W-1:0];
            r_lon   <= i_s_tdata[TIME_W+LON_W-1:TIME_W];
            r_lat   <= i_s_tdata[IN_FLD_W-1:TIME_W+LON_W];
            r_track <= i_s_tuser;
        end
    end

    gcc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gcc_zone_test u_zone_test (
        .i_cfg      (cfg),
        .i_fix_time (r_time),
        .i_fix_lon  (r_lon),
        .i_fix_lat  (r_lat),
        .o_hits     (hits)
    );

    gcc_tally u_tally (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fix_valid   (r_in_valid),
        .i_track_start (r_track),
        .i_hits        (hits),
        .i_out_ready   (i_m_tready),
        .o_advance     (advance),
        .o_out_valid   (o_m_tvalid),
        .o_total       (total),
        .o_now         (now_cnt),
        .o_zone        (zone)
    );

    assign o_m_tdata = {(OUT_DATA_W - OUT_FLD_W)'(0), zone, now_cnt, total};

endmodule
